// ----- hdl/rsm_pkg.sv -----
// Package for the surface-of-revolution mesher: sizes, op codes, register
// indexes, result record, CORDIC arctangent table and output rounding.
// No dependencies.
package rsm_pkg;

    localparam int MAX_POINTS   = 64;
    localparam int MAX_STEPS    = 256;
    localparam int PHASE_BITS   = 12;
    localparam int CORDIC_ITERS = 16;
    localparam int TRIG_FRAC    = 14;
    localparam int CORDIC_GAIN  = 9949;

    localparam int COORD_W    = 16;
    localparam int TRIG_W     = 18;
    localparam int ANG_W      = 32;
    localparam int IDX_W      = 15;
    localparam int STEP_W     = 8;
    localparam int POINT_W    = $clog2(MAX_POINTS);
    localparam int ENTRY_W    = 3 * COORD_W;
    localparam int ITER_W     = $clog2(CORDIC_ITERS);
    localparam int STEPS_W    = 9;
    localparam int POINTS_W   = 7;
    localparam int ANGLE_W    = 12;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int PROD_W     = COORD_W + TRIG_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int ROUND_HALF = 1 << (TRIG_FRAC - 1);
    localparam int COORD_MAX  = (1 << (COORD_W - 1)) - 1;
    localparam int COORD_MIN  = -(1 << (COORD_W - 1));

    typedef enum logic [2:0] {
        OP_WRITE  = 3'd0,
        OP_VERTEX = 3'd1,
        OP_SIDE   = 3'd2,
        OP_BOTTOM = 3'd3,
        OP_TOP    = 3'd4
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEPS  = 2'd0,
        CFG_POINTS = 2'd1,
        CFG_ANGLE  = 2'd2,
        CFG_CAPS   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [IDX_W-1:0]          a;
        logic [IDX_W-1:0]          b;
        logic [IDX_W-1:0]          c;
        logic                      present;
        logic                      bad;
    } t_result;

    // atan(2^-k) in units of 2^32 per turn
    function automatic logic signed [ANG_W-1:0] atan_lut(input logic [ITER_W-1:0] k);
        logic signed [ANG_W-1:0] v;
        case (k)
            4'd0:    v = 32'h20000000;
            4'd1:    v = 32'h12E4051E;
            4'd2:    v = 32'h09FB385B;
            4'd3:    v = 32'h051111D4;
            4'd4:    v = 32'h028B0D43;
            4'd5:    v = 32'h0145D7E1;
            4'd6:    v = 32'h00A2F61E;
            4'd7:    v = 32'h00517C55;
            4'd8:    v = 32'h0028BE53;
            4'd9:    v = 32'h00145F2F;
            4'd10:   v = 32'h000A2F98;
            4'd11:   v = 32'h000517CC;
            4'd12:   v = 32'h00028BE6;
            4'd13:   v = 32'h000145F3;
            4'd14:   v = 32'h0000A2FA;
            4'd15:   v = 32'h0000517D;
            default: v = '0;
        endcase
        return v;
    endfunction

    // round half up to Q8.8 (floor shift) and saturate to 16 bits
    function automatic logic signed [COORD_W-1:0] round_sat(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [SUM_W-1:0]           t;
        logic signed [SUM_W-TRIG_FRAC-1:0] q;
        logic signed [COORD_W-1:0]         r;
        t = v + SUM_W'(ROUND_HALF);
        q = t[SUM_W-1:TRIG_FRAC];
        if (q > $signed((SUM_W - TRIG_FRAC)'(COORD_MAX))) begin
            r = COORD_W'(COORD_MAX);
        end else if (q < $signed((SUM_W - TRIG_FRAC)'(COORD_MIN))) begin
            r = COORD_W'(COORD_MIN);
        end else begin
            r = q[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- hdl/revolution_surface_mesher_top.sv -----
// Surface-of-revolution mesher top level: profile store, CORDIC rotation,
// triangle index generation. Depends on rsm_pkg and rsm_ram.
//
// Usage:
//   Configuration: write steps, profile_points, angle_step and caps_enable
//   through i_cfg_we / i_cfg_idx / i_cfg_wdata while the block is idle.
//   Commands: a transaction is taken at a rising edge with start high and
//   busy low. Op 0 writes a profile point; ops 1..4 query a rotated vertex,
//   a side triangle, or a bottom / top cap triangle (with its centre).
//   Results: every command returns exactly one result, shown for one cycle
//   with o_valid high. The receiver cannot stall, so it must take it then.
// Sequencing:
//   Writes, triangle and cap queries: profile RAM read, then index
//   arithmetic; no new command is taken until the result is shown.
//   Vertex queries: RAM read, 16 CORDIC iterations on one shared
//   shift-add unit, then the x*c, z*s, z*c, x*s and final z steps on one
//   shared 16x18 multiplier, whose last step registers the result.
//   busy drops in the cycle the result is shown, so the next command can be
//   taken in that cycle.
// Reset: i_rst_n (synchronous, active low) restores the configuration
//   defaults and idles the controller. The profile RAM is not cleared; a
//   point must be written before any query reads it.
module revolution_surface_mesher_top import rsm_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                       start,
    output logic                       busy,
    input  logic [2:0]                 i_op,
    input  logic [STEP_W-1:0]          i_step,
    input  logic [POINT_W-1:0]         i_point,
    input  logic                       i_half,
    input  logic signed [COORD_W-1:0]  i_x_in,
    input  logic signed [COORD_W-1:0]  i_y_in,
    input  logic signed [COORD_W-1:0]  i_z_in,
    output logic                       o_valid,
    output logic signed [COORD_W-1:0]  o_x_out,
    output logic signed [COORD_W-1:0]  o_y_out,
    output logic signed [COORD_W-1:0]  o_z_out,
    output logic [IDX_W-1:0]           o_corner_a,
    output logic [IDX_W-1:0]           o_corner_b,
    output logic [IDX_W-1:0]           o_corner_c,
    output logic                       o_present,
    output logic                       o_bad_index
);

    // multiplier schedule: x*c, z*s, z*c, x*s, then final z
    localparam logic [2:0] MK_XC   = 3'd0;
    localparam logic [2:0] MK_ZS   = 3'd1;
    localparam logic [2:0] MK_ZC   = 3'd2;
    localparam logic [2:0] MK_XS   = 3'd3;
    localparam logic [2:0] MK_LAST = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_ROT,
        S_MUL
    } t_state;

    // ---------------- configuration registers ----------------
    logic [STEPS_W-1:0]  r_steps;
    logic [POINTS_W-1:0] r_profile_points;
    logic [ANGLE_W-1:0]  r_angle_step;
    logic                r_caps_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps          <= STEPS_W'(16);
            r_profile_points <= POINTS_W'(4);
            r_angle_step     <= ANGLE_W'(256);
            r_caps_enable    <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_STEPS:  r_steps          <= i_cfg_wdata[STEPS_W-1:0];
                CFG_POINTS: r_profile_points <= i_cfg_wdata[POINTS_W-1:0];
                CFG_ANGLE:  r_angle_step     <= i_cfg_wdata[ANGLE_W-1:0];
                CFG_CAPS:   r_caps_enable    <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ---------------- controller registers ----------------
    t_state                    r_state;
    t_op                       r_op;
    logic [POINT_W-1:0]        r_point;
    logic                      r_half;
    logic                      r_bad;
    logic [PHASE_BITS-1:0]     r_phase;
    logic [IDX_W-1:0]          r_jp;     // j * P
    logic [IDX_W-1:0]          r_jnp;    // ((j+1) mod n) * P
    logic [IDX_W-1:0]          r_pn;     // P * n (bottom centre index)
    logic [ITER_W-1:0]         r_it;
    logic signed [TRIG_W-1:0]  r_cx;
    logic signed [TRIG_W-1:0]  r_cy;
    logic signed [ANG_W-1:0]   r_cz;
    logic signed [TRIG_W-1:0]  r_cos;
    logic signed [TRIG_W-1:0]  r_sin;
    logic signed [COORD_W-1:0] r_px;
    logic signed [COORD_W-1:0] r_pz;
    logic [2:0]                r_mk;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [PROD_W-1:0]  r_acc;
    logic                      r_valid;
    t_result                   r_res;

    // ---------------- command decode (accept cycle) ----------------
    logic [STEPS_W-1:0]            steps_eff;
    logic [POINTS_W-1:0]           points_eff;
    logic                          accept;
    t_op                           op_in;
    logic [STEPS_W-1:0]            step_ext;
    logic [STEPS_W-1:0]            step_inc;
    logic [STEPS_W-1:0]            step_next;
    logic [POINTS_W-1:0]           pt_ext;
    logic                          step_bad;
    logic                          bad_in;
    logic [POINT_W-1:0]            raddr_a;
    logic                          ram_we;
    logic [STEP_W+ANGLE_W-1:0]     phase_full;
    logic [STEPS_W+POINTS_W-1:0]   jp_full;
    logic [STEPS_W+POINTS_W-1:0]   jnp_full;
    logic [STEPS_W+POINTS_W-1:0]   pn_full;

    always_comb begin
        // registers used clamped to their legal ranges
        if (r_steps == '0) begin
            steps_eff = STEPS_W'(1);
        end else if (r_steps > STEPS_W'(MAX_STEPS)) begin
            steps_eff = STEPS_W'(MAX_STEPS);
        end else begin
            steps_eff = r_steps;
        end
        if (r_profile_points < POINTS_W'(2)) begin
            points_eff = POINTS_W'(2);
        end else if (r_profile_points > POINTS_W'(MAX_POINTS)) begin
            points_eff = POINTS_W'(MAX_POINTS);
        end else begin
            points_eff = r_profile_points;
        end

        accept    = start && (r_state == S_IDLE);
        op_in     = t_op'(i_op);
        step_ext  = STEPS_W'(i_step);
        step_inc  = step_ext + STEPS_W'(1);
        step_next = (step_inc == steps_eff) ? '0 : step_inc;
        pt_ext    = POINTS_W'(i_point);
        step_bad  = step_ext >= steps_eff;

        case (op_in)
            OP_WRITE:  bad_in = pt_ext >= POINTS_W'(MAX_POINTS);
            OP_VERTEX: bad_in = (pt_ext >= points_eff) || step_bad;
            OP_SIDE:   bad_in = ((pt_ext + POINTS_W'(1)) >= points_eff) || step_bad;
            OP_BOTTOM: bad_in = step_bad;
            OP_TOP:    bad_in = step_bad;
            default:   bad_in = 1'b1;
        endcase

        // the top cap reads the last profile point instead of the queried one
        raddr_a = (op_in == OP_TOP) ? POINT_W'(points_eff - POINTS_W'(1)) : i_point;
        ram_we  = accept && (op_in == OP_WRITE) && !bad_in;

        phase_full = i_step * r_angle_step;
        jp_full    = step_ext * points_eff;
        jnp_full   = step_next * points_eff;
        pn_full    = steps_eff * points_eff;
    end

    // ---------------- profile store ----------------
    logic [ENTRY_W-1:0] rd_a;
    logic [ENTRY_W-1:0] rd_b;

    rsm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_POINTS)
    ) u_profile_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (i_point),
        .i_wdata   ({i_x_in, i_y_in, i_z_in}),
        .i_re      (accept),
        .i_raddr_a (raddr_a),
        .i_raddr_b (POINT_W'(0)),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // ---------------- fetch-cycle result ----------------
    logic signed [COORD_W-1:0] xa;
    logic signed [COORD_W-1:0] ya;
    logic signed [COORD_W-1:0] za;
    logic signed [COORD_W-1:0] x0;
    logic signed [COORD_W-1:0] y0;
    logic                      cap_bot;
    logic                      cap_top;
    logic [IDX_W-1:0]          pt_idx;
    logic [IDX_W-1:0]          p_idx;
    t_result                   fetch_res;

    always_comb begin
        xa      = $signed(rd_a[3*COORD_W-1:2*COORD_W]);
        ya      = $signed(rd_a[2*COORD_W-1:COORD_W]);
        za      = $signed(rd_a[COORD_W-1:0]);
        x0      = $signed(rd_b[3*COORD_W-1:2*COORD_W]);
        y0      = $signed(rd_b[2*COORD_W-1:COORD_W]);
        cap_bot = r_caps_enable && (x0 != '0);
        cap_top = r_caps_enable && (xa != '0);
        pt_idx  = IDX_W'(r_point);
        p_idx   = IDX_W'(points_eff);

        fetch_res         = '0;
        fetch_res.present = 1'b1;
        fetch_res.bad     = r_bad;
        case (r_op)
            OP_WRITE: ;
            OP_VERTEX: begin
                if (!r_bad) begin
                    fetch_res.y = ya;
                end
            end
            OP_SIDE: begin
                if (!r_bad) begin
                    if (!r_half) begin
                        fetch_res.a = pt_idx + r_jnp;
                        fetch_res.b = pt_idx + IDX_W'(1) + r_jnp;
                        fetch_res.c = pt_idx + IDX_W'(1) + r_jp;
                    end else begin
                        fetch_res.a = pt_idx + r_jp;
                        fetch_res.b = pt_idx + r_jnp;
                        fetch_res.c = pt_idx + IDX_W'(1) + r_jp;
                    end
                end
            end
            OP_BOTTOM: begin
                fetch_res.present = cap_bot;
                if (!r_bad && cap_bot) begin
                    fetch_res.y = y0;
                    fetch_res.a = r_pn;
                    fetch_res.b = r_jnp;
                    fetch_res.c = r_jp;
                end
            end
            OP_TOP: begin
                fetch_res.present = cap_top;
                if (!r_bad && cap_top) begin
                    // top centre moves down one slot when the bottom cap is absent
                    fetch_res.y = ya;
                    fetch_res.a = r_pn + IDX_W'(cap_bot);
                    fetch_res.b = r_jp + p_idx - IDX_W'(1);
                    fetch_res.c = r_jnp + p_idx - IDX_W'(1);
                end
            end
            default: begin
                fetch_res.present = 1'b0;
                fetch_res.bad     = 1'b1;
            end
        endcase
    end

    // ---------------- CORDIC iteration and multiplier ----------------
    logic signed [TRIG_W-1:0]  sh_x;
    logic signed [TRIG_W-1:0]  sh_y;
    logic signed [TRIG_W-1:0]  n_cx;
    logic signed [TRIG_W-1:0]  n_cy;
    logic signed [ANG_W-1:0]   n_cz;
    logic signed [TRIG_W-1:0]  n_cos;
    logic signed [TRIG_W-1:0]  n_sin;
    logic signed [COORD_W-1:0] mul_a;
    logic signed [TRIG_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [SUM_W-1:0]   sum_x;
    logic signed [SUM_W-1:0]   sum_z;

    always_comb begin
        sh_x = r_cx >>> r_it;
        sh_y = r_cy >>> r_it;
        if (!r_cz[ANG_W-1]) begin
            n_cx = r_cx - sh_y;
            n_cy = r_cy + sh_x;
            n_cz = r_cz - atan_lut(r_it);
        end else begin
            n_cx = r_cx + sh_y;
            n_cy = r_cy - sh_x;
            n_cz = r_cz + atan_lut(r_it);
        end

        // fold the quadrant back in
        case (r_phase[PHASE_BITS-1 -: 2])
            2'd0:    begin n_cos = n_cx;  n_sin = n_cy;  end
            2'd1:    begin n_cos = -n_cy; n_sin = n_cx;  end
            2'd2:    begin n_cos = -n_cx; n_sin = -n_cy; end
            default: begin n_cos = n_cy;  n_sin = -n_cx; end
        endcase

        case (r_mk)
            MK_XC:   begin mul_a = r_px; mul_b = r_cos; end
            MK_ZS:   begin mul_a = r_pz; mul_b = r_sin; end
            MK_ZC:   begin mul_a = r_pz; mul_b = r_cos; end
            MK_XS:   begin mul_a = r_px; mul_b = r_sin; end
            default: begin mul_a = r_px; mul_b = r_cos; end
        endcase
        mul_p = mul_a * mul_b;

        sum_x = SUM_W'(r_acc) + SUM_W'(r_prod);
        sum_z = SUM_W'(r_acc) - SUM_W'(r_prod);
    end

    // ---------------- controller ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op    <= op_in;
                        r_point <= i_point;
                        r_half  <= i_half;
                        r_bad   <= bad_in;
                        r_phase <= phase_full[PHASE_BITS-1:0];
                        r_jp    <= jp_full[IDX_W-1:0];
                        r_jnp   <= jnp_full[IDX_W-1:0];
                        r_pn    <= pn_full[IDX_W-1:0];
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    r_res <= fetch_res;
                    if (r_op == OP_VERTEX && !r_bad) begin
                        r_px    <= xa;
                        r_pz    <= za;
                        r_cx    <= TRIG_W'(CORDIC_GAIN);
                        r_cy    <= '0;
                        r_cz    <= {2'b00, r_phase[PHASE_BITS-3:0],
                                    (ANG_W - PHASE_BITS)'(0)};
                        r_it    <= '0;
                        r_state <= S_ROT;
                    end else begin
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_ROT: begin
                    r_cx <= n_cx;
                    r_cy <= n_cy;
                    r_cz <= n_cz;
                    r_it <= r_it + ITER_W'(1);
                    if (r_it == ITER_W'(CORDIC_ITERS - 1)) begin
                        r_cos   <= n_cos;
                        r_sin   <= n_sin;
                        r_mk    <= MK_XC;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod <= mul_p;
                    r_mk   <= r_mk + 3'd1;
                    case (r_mk)
                        MK_ZS:   r_acc <= r_prod;
                        MK_ZC:   r_res.x <= round_sat(sum_x);
                        MK_XS:   r_acc <= r_prod;
                        MK_LAST: begin
                            r_res.z <= round_sat(sum_z);
                            r_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end
                        default: ;
                    endcase
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_x_out     = r_res.x;
    assign o_y_out     = r_res.y;
    assign o_z_out     = r_res.z;
    assign o_corner_a  = r_res.a;
    assign o_corner_b  = r_res.b;
    assign o_corner_c  = r_res.c;
    assign o_present   = r_res.present;
    assign o_bad_index = r_res.bad;

    // ---------------- assertions ----------------
    a_valid_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_index) |-> (o_x_out == '0 && o_z_out == '0 &&
            o_corner_a == '0 && o_corner_b == '0 && o_corner_c == '0))
        else $error("bad index result carries data");

    a_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_present) |-> (o_y_out == '0 && o_corner_a == '0))
        else $error("absent cap result carries data");

endmodule

// ----- hdl/rsm_ram.sv -----
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module rsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule
